// ===== src/klex_pkg.sv =====
// shared types, token codes and keyword table for the keyword lexer
`default_nettype none

package klex_pkg;

  // lexer modes, one-hot
  typedef enum logic [9:0] {
    MODE_IDLE    = 10'b00_0000_0001,
    MODE_WORD    = 10'b00_0000_0010,
    MODE_NUM     = 10'b00_0000_0100,
    MODE_BANG    = 10'b00_0000_1000,
    MODE_EQ      = 10'b00_0001_0000,
    MODE_GT      = 10'b00_0010_0000,
    MODE_LT      = 10'b00_0100_0000,
    MODE_SLASH   = 10'b00_1000_0000,
    MODE_COMMENT = 10'b01_0000_0000,
    MODE_CSTAR   = 10'b10_0000_0000
  } klex_mode_t;

  // token codes
  localparam logic [4:0] TOK_ID     = 5'd0;
  localparam logic [4:0] TOK_NUM    = 5'd1;
  localparam logic [4:0] TOK_KW0    = 5'd2;
  localparam logic [4:0] TOK_DIV    = 5'd10;
  localparam logic [4:0] TOK_NE     = 5'd11;
  localparam logic [4:0] TOK_EQEQ   = 5'd12;
  localparam logic [4:0] TOK_ASSIGN = 5'd13;
  localparam logic [4:0] TOK_LPAR   = 5'd14;
  localparam logic [4:0] TOK_RPAR   = 5'd15;
  localparam logic [4:0] TOK_SEMI   = 5'd16;
  localparam logic [4:0] TOK_LBRACE = 5'd17;
  localparam logic [4:0] TOK_RBRACE = 5'd18;
  localparam logic [4:0] TOK_PLUS   = 5'd19;
  localparam logic [4:0] TOK_GE     = 5'd20;
  localparam logic [4:0] TOK_GT     = 5'd21;
  localparam logic [4:0] TOK_LE     = 5'd22;
  localparam logic [4:0] TOK_LT     = 5'd23;
  localparam logic [4:0] TOK_STAR   = 5'd24;
  localparam logic [4:0] TOK_MINUS  = 5'd25;
  localparam logic [4:0] TOK_ERR    = 5'd26;
  localparam logic [4:0] TOK_END    = 5'd27;

  // byte codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  localparam int KW_COUNT = 8;
  localparam int PREFIX_BYTES = 5;
  localparam logic [2:0] LEN_SAT = 3'd6;

  // keywords packed first byte low, with their lengths
  localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
    40'h00_0000_6669,  // if
    40'h00_0072_6f66,  // for
    40'h00_6573_6c65,  // else
    40'h65_6c69_6877,  // while
    40'h00_0000_6f64,  // do
    40'h74_616f_6c66,  // float
    40'h00_0074_6e69,  // int
    40'h6b_6165_7262   // break
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd5, 3'd3, 3'd5
  };

  // one queued result
  typedef struct packed {
    logic [4:0] kind;
    logic       err;
    logic       last;
  } klex_ent_t;

  // up to two results written into the queue by one request
  typedef struct packed {
    logic      v0;
    logic      v1;
    klex_ent_t e0;
    klex_ent_t e1;
  } klex_push_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // keyword match of a finished word, identifier otherwise
  function automatic logic [4:0] word_kind(logic [39:0] prefix, logic [2:0] len);
    logic [4:0] kind;
    kind = TOK_ID;
    for (int i = 0; i < KW_COUNT; i++) begin
      if ((len == KW_LEN[i]) && (prefix == KW_TEXT[i])) begin
        kind = TOK_KW0 + 5'(i);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

// ===== src/klex_queue.sv =====
// four-entry result queue taking up to two results per request
`default_nettype none

module klex_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire klex_pkg::klex_push_t push_data,
  output logic                     full,
  output logic                     head_valid,
  output klex_pkg::klex_ent_t      head,
  input  wire logic                pop
);
  import klex_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  klex_ent_t       ent_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      n_push;
  logic            do_pop;

  // room for two is required before a new request is taken
  assign full       = (cnt_r > CW'(DEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = ent_r[rd_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    n_push = push ? (2'(push_data.v0) + 2'(push_data.v1)) : 2'd0;
    wr_nxt = wr_r + PW'(n_push);
    rd_nxt = rd_r + PW'(do_pop);
    cnt_nxt = cnt_r + CW'(n_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_data.v0) begin
      ent_r[wr_r] <= push_data.e0;
    end
    if (push && push_data.v1) begin
      ent_r[wr_r + PW'(1)] <= push_data.e1;
    end
  end

  // a second result never arrives without a first
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_data.v0 || !push_data.v1))
    else $error("klex_queue: second slot written without first");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("klex_queue: count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (cnt_r == $past(cnt_nxt)))
    else $error("klex_queue: count lost track");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != CW'(DEPTH)) |-> (PW'(cnt_r) == PW'(wr_r - rd_r)))
    else $error("klex_queue: pointers disagree with count");

endmodule

`default_nettype wire

// ===== src/keyword_lexer_unit.sv =====
// top level of the keyword lexer: byte in, token codes out
//
// One source byte is taken per request on the in_ channel and turned into
// zero, one or two tokens on the out_ channel. The lexer state (mode, the
// first five bytes of a word, its length, the number-has-letter bit and the
// sticky error flag) updates in the same cycle that the byte is taken, and
// the tokens it causes go into a four-entry result queue, so a byte can be
// taken every cycle while in_stall is low and its tokens leave in order. The
// queue drains one token per cycle while out_stall is low; in_stall rises
// while fewer than two entries are free, so a byte that gives two tokens (a
// pending word, number or operator closed by the next token) fills two queue
// entries, and a waiting sink holds off input once the queue fills. Every token
// carries the error flag as it stands after that token; on the end-of-line
// token it is the line's verdict, and the flag clears once the line ends.
// out_last_of_item marks the last token caused by a byte.
`default_nettype none

module keyword_lexer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte requests
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  // token requests
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [4:0]      out_token_kind,
  output logic            out_error_seen,
  output logic            out_last_of_item
);
  import klex_pkg::*;

  // lexer state
  klex_mode_t  mode_r, mode_nxt;
  logic [39:0] prefix_r, prefix_nxt;
  logic [2:0]  len_r, len_nxt;
  logic        hasl_r, hasl_nxt;
  logic        err_r, err_nxt;

  logic        accept;
  logic [7:0]  c;
  logic        c_letter, c_digit;

  // pending token closed by this byte
  logic        a_v;
  logic [4:0]  a_kind;
  logic        a_err;
  // token from the byte itself (after any hand-back)
  logic        b_v;
  logic [4:0]  b_kind;
  logic        b_err;
  logic        do_idle;
  logic        err_mid;

  klex_push_t  push_data;
  klex_ent_t   head;
  logic        q_full;

  assign c        = in_char_in;
  assign c_letter = is_letter(c);
  assign c_digit  = is_digit(c);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    mode_nxt   = mode_r;
    prefix_nxt = prefix_r;
    len_nxt    = len_r;
    hasl_nxt   = hasl_r;
    a_v        = 1'b0;
    a_kind     = TOK_ID;
    a_err      = err_r;
    b_v        = 1'b0;
    b_kind     = TOK_ID;
    do_idle    = 1'b0;
    err_mid    = err_r;

    // first pass: what the current mode makes of the byte
    case (mode_r)
      MODE_WORD, MODE_NUM: begin
        if (c_letter || c_digit) begin
          // append to the run, keep only the first five bytes
          for (int i = 0; i < PREFIX_BYTES; i++) begin
            if (len_r == 3'(i)) begin
              prefix_nxt[8*i +: 8] = c;
            end
          end
          if (len_r < LEN_SAT) begin
            len_nxt = len_r + 3'd1;
          end
          if (c_letter) begin
            hasl_nxt = 1'b1;
          end
        end else begin
          // run ends, byte is lexed again from idle
          a_v = 1'b1;
          if (mode_r == MODE_WORD) begin
            a_kind = (len_r > 3'(PREFIX_BYTES)) ? TOK_ID : word_kind(prefix_r, len_r);
          end else begin
            a_kind = hasl_r ? TOK_ID : TOK_NUM;
          end
          prefix_nxt = '0;
          len_nxt    = '0;
          hasl_nxt   = 1'b0;
          do_idle    = 1'b1;
        end
      end
      MODE_BANG: begin
        mode_nxt = MODE_IDLE;
        a_v = 1'b1;
        if (c == CH_EQ) begin
          a_kind = TOK_NE;
        end else begin
          // lone bang is an error
          err_mid = 1'b1;
          a_kind  = TOK_ERR;
          a_err   = 1'b1;
          do_idle = 1'b1;
        end
      end
      MODE_EQ: begin
        mode_nxt = MODE_IDLE;
        a_v = 1'b1;
        if (c == CH_EQ) begin
          a_kind = TOK_EQEQ;
        end else begin
          a_kind  = TOK_ASSIGN;
          do_idle = 1'b1;
        end
      end
      MODE_GT: begin
        mode_nxt = MODE_IDLE;
        a_v = 1'b1;
        if (c == CH_EQ) begin
          a_kind = TOK_GE;
        end else begin
          a_kind  = TOK_GT;
          do_idle = 1'b1;
        end
      end
      MODE_LT: begin
        mode_nxt = MODE_IDLE;
        a_v = 1'b1;
        if (c == CH_EQ) begin
          a_kind = TOK_LE;
        end else begin
          a_kind  = TOK_LT;
          do_idle = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (c == CH_STAR) begin
          mode_nxt = MODE_COMMENT;
        end else begin
          a_v     = 1'b1;
          a_kind  = TOK_DIV;
          do_idle = 1'b1;
        end
      end
      MODE_COMMENT: begin
        // newline abandons the comment and ends the line
        if (c == CH_NL) begin
          do_idle = 1'b1;
        end else if (c == CH_STAR) begin
          mode_nxt = MODE_CSTAR;
        end
      end
      MODE_CSTAR: begin
        if (c == CH_NL) begin
          do_idle = 1'b1;
        end else if (c == CH_SLASH) begin
          mode_nxt = MODE_IDLE;
        end else if (c != CH_STAR) begin
          mode_nxt = MODE_COMMENT;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    err_nxt = err_mid;
    b_err   = err_mid;

    // second pass: the byte as seen from idle
    if (do_idle) begin
      mode_nxt = MODE_IDLE;
      if (c_letter || c_digit) begin
        mode_nxt   = c_letter ? MODE_WORD : MODE_NUM;
        prefix_nxt = {32'd0, c};
        len_nxt    = 3'd1;
        hasl_nxt   = 1'b0;
      end else begin
        case (c)
          CH_SPACE, CH_TAB: begin
          end
          CH_NL: begin
            // end of line carries the verdict, then the flag clears
            b_v     = 1'b1;
            b_kind  = TOK_END;
            err_nxt = 1'b0;
          end
          CH_SLASH:  mode_nxt = MODE_SLASH;
          CH_BANG:   mode_nxt = MODE_BANG;
          CH_EQ:     mode_nxt = MODE_EQ;
          CH_GT:     mode_nxt = MODE_GT;
          CH_LT:     mode_nxt = MODE_LT;
          CH_LPAR: begin
            b_v = 1'b1; b_kind = TOK_LPAR;
          end
          CH_RPAR: begin
            b_v = 1'b1; b_kind = TOK_RPAR;
          end
          CH_SEMI: begin
            b_v = 1'b1; b_kind = TOK_SEMI;
          end
          CH_LBRACE: begin
            b_v = 1'b1; b_kind = TOK_LBRACE;
          end
          CH_RBRACE: begin
            b_v = 1'b1; b_kind = TOK_RBRACE;
          end
          CH_PLUS: begin
            b_v = 1'b1; b_kind = TOK_PLUS;
          end
          CH_MINUS: begin
            b_v = 1'b1; b_kind = TOK_MINUS;
          end
          CH_STAR: begin
            b_v = 1'b1; b_kind = TOK_STAR;
          end
          default: begin
            // unknown byte, including '|', '&' and anything non-ascii
            b_v     = 1'b1;
            b_kind  = TOK_ERR;
            b_err   = 1'b1;
            err_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  // pack tokens in order, first valid token into slot zero
  always_comb begin
    push_data.v0      = a_v || b_v;
    push_data.v1      = a_v && b_v;
    push_data.e0.kind = a_v ? a_kind : b_kind;
    push_data.e0.err  = a_v ? a_err : b_err;
    push_data.e0.last = !(a_v && b_v);
    push_data.e1.kind = b_kind;
    push_data.e1.err  = b_err;
    push_data.e1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      prefix_r <= '0;
      len_r    <= '0;
      hasl_r   <= 1'b0;
      err_r    <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      prefix_r <= prefix_nxt;
      len_r    <= len_nxt;
      hasl_r   <= hasl_nxt;
      err_r    <= err_nxt;
    end
  end

  klex_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (out_valid),
    .head       (head),
    .pop        (!out_stall)
  );

  assign out_token_kind   = head.kind;
  assign out_error_seen   = head.err;
  assign out_last_of_item = head.last;

  // run length saturates at six
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_SAT)
    else $error("keyword_lexer_unit: run length past saturation");

  // the line ends with a clear flag
  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && b_v && (b_kind == TOK_END)) |=> !err_r)
    else $error("keyword_lexer_unit: error flag survived end of line");

  // an error token always reports the flag set
  a_err_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == TOK_ERR)) |-> out_error_seen)
    else $error("keyword_lexer_unit: error token without flag");

  // outside a run the word registers are not consulted, inside one length is nonzero
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == MODE_WORD) || (mode_r == MODE_NUM)) |-> (len_r != 3'd0))
    else $error("keyword_lexer_unit: empty run");

endmodule

`default_nettype wire

// ===== bench/keyword_lexer_unit_tb.sv =====
// self-checking testbench for the keyword lexer: directed table, then random source text
`default_nettype none

module keyword_lexer_unit_tb;
  import klex_pkg::*;

  // clock, reset and ports, every input known from time zero
  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_token_kind;
  logic       out_error_seen;
  logic       out_last_of_item;

  keyword_lexer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_error_seen   (out_error_seen),
    .out_last_of_item (out_last_of_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one token as it should leave the block
  typedef struct packed {
    logic [4:0] kind;
    logic       err;
    logic       last;
  } token_t;

  token_t     tokens_due[$];   // tokens still owed by the block, oldest first
  token_t     step_toks[$];    // tokens caused by the byte just lexed
  logic [7:0] src_bytes[$];    // random source text waiting to be sent
  int         mismatches = 0;
  int         idle_pct = 0;    // chance per cycle that the sender holds off
  int         stall_pct = 0;   // chance per cycle that the sink stalls

  // lexer state as the block should hold it
  klex_mode_t  lex_mode = MODE_IDLE;
  logic [39:0] word_text = '0;   // first five bytes of the run, first byte low
  logic [2:0]  word_len = '0;    // run length, stops at six
  logic        word_has_letter = 1'b0;
  logic        err_sticky = 1'b0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic string kw_name(input int i);
    case (i)
      0: return "if";
      1: return "for";
      2: return "else";
      3: return "while";
      4: return "do";
      5: return "float";
      6: return "int";
      default: return "break";
    endcase
  endfunction

  function automatic logic [39:0] packed_text(input string s);
    logic [39:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 5; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // keyword code of the finished word; six bytes or more is always an identifier
  function automatic logic [4:0] keyword_code();
    logic [4:0] code;
    code = TOK_ID;
    if (word_len <= 3'd5) begin
      for (int i = 0; i < 8; i++) begin
        if (word_len == kw_name(i).len() && word_text == packed_text(kw_name(i)))
          code = TOK_KW0 + 5'(i);
      end
    end
    return code;
  endfunction

  // every token carries the flag as it stands after that token
  task automatic emit_tok(input logic [4:0] kind);
    token_t t;
    t.kind = kind;
    t.err = err_sticky;
    t.last = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic grow_word(input logic [7:0] c);
    if (word_len < 3'd5) word_text[8*word_len +: 8] = c;
    if (word_len < 3'd6) word_len++;
  endtask

  task automatic open_run(input klex_mode_t m, input logic [7:0] c);
    lex_mode = m;
    word_text = '0;
    word_len = '0;
    word_has_letter = 1'b0;
    grow_word(c);
  endtask

  // a byte seen with nothing pending, also the byte handed back by a token
  task automatic lex_fresh(input logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (alpha_byte(c)) begin
      open_run(MODE_WORD, c);
    end else if (digit_byte(c)) begin
      open_run(MODE_NUM, c);
    end else begin
      case (c)
        CH_SPACE, CH_TAB: ;
        CH_NL: begin
          emit_tok(TOK_END);
          err_sticky = 1'b0;
        end
        CH_SLASH:  lex_mode = MODE_SLASH;
        CH_BANG:   lex_mode = MODE_BANG;
        CH_EQ:     lex_mode = MODE_EQ;
        CH_GT:     lex_mode = MODE_GT;
        CH_LT:     lex_mode = MODE_LT;
        CH_LPAR:   emit_tok(TOK_LPAR);
        CH_RPAR:   emit_tok(TOK_RPAR);
        CH_SEMI:   emit_tok(TOK_SEMI);
        CH_LBRACE: emit_tok(TOK_LBRACE);
        CH_RBRACE: emit_tok(TOK_RBRACE);
        CH_PLUS:   emit_tok(TOK_PLUS);
        CH_MINUS:  emit_tok(TOK_MINUS);
        CH_STAR:   emit_tok(TOK_STAR);
        default: begin
          err_sticky = 1'b1;
          emit_tok(TOK_ERR);
        end
      endcase
    end
  endtask

  // tokens caused by one accepted byte, left in step_toks
  task automatic lex_step(input logic [7:0] c);
    token_t t;
    step_toks.delete();
    case (lex_mode)
      MODE_WORD, MODE_NUM: begin
        if (alpha_byte(c) || digit_byte(c)) begin
          grow_word(c);
          if (alpha_byte(c)) word_has_letter = 1'b1;
        end else begin
          if (lex_mode == MODE_WORD) emit_tok(keyword_code());
          else emit_tok(word_has_letter ? TOK_ID : TOK_NUM);
          word_text = '0;
          word_len = '0;
          word_has_letter = 1'b0;
          lex_fresh(c);
        end
      end
      MODE_BANG: begin
        lex_mode = MODE_IDLE;
        if (c == CH_EQ) begin
          emit_tok(TOK_NE);
        end else begin
          err_sticky = 1'b1;
          emit_tok(TOK_ERR);
          lex_fresh(c);
        end
      end
      MODE_EQ: begin
        lex_mode = MODE_IDLE;
        if (c == CH_EQ) begin
          emit_tok(TOK_EQEQ);
        end else begin
          emit_tok(TOK_ASSIGN);
          lex_fresh(c);
        end
      end
      MODE_GT: begin
        lex_mode = MODE_IDLE;
        if (c == CH_EQ) begin
          emit_tok(TOK_GE);
        end else begin
          emit_tok(TOK_GT);
          lex_fresh(c);
        end
      end
      MODE_LT: begin
        lex_mode = MODE_IDLE;
        if (c == CH_EQ) begin
          emit_tok(TOK_LE);
        end else begin
          emit_tok(TOK_LT);
          lex_fresh(c);
        end
      end
      MODE_SLASH: begin
        if (c == CH_STAR) begin
          lex_mode = MODE_COMMENT;
        end else begin
          emit_tok(TOK_DIV);
          lex_fresh(c);
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL) lex_fresh(c);
        else if (c == CH_STAR) lex_mode = MODE_CSTAR;
      end
      MODE_CSTAR: begin
        if (c == CH_NL) lex_fresh(c);
        else if (c == CH_SLASH) lex_mode = MODE_IDLE;
        else if (c != CH_STAR) lex_mode = MODE_COMMENT;
      end
      default: lex_fresh(c);
    endcase
    // mark the byte's final token
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  // one byte request, with random hold-off before it is offered
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    // values seen here are those from just before the edge
    while (in_stall) @(posedge clk);
    lex_step(c);
  endtask

  task automatic queue_predicted();
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endtask

  function automatic string op_text(input int i);
    case (i)
      0:  return "!=";
      1:  return "==";
      2:  return "=";
      3:  return ">=";
      4:  return ">";
      5:  return "<=";
      6:  return "<";
      7:  return "/";
      8:  return "(";
      9:  return ")";
      10: return ";";
      11: return "{";
      12: return "}";
      13: return "+";
      14: return "*";
      15: return "-";
      16: return "!";
      17: return "|";
      default: return "&";
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 3) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter();
  endfunction

  // comment bodies lean on stars and slashes to hit the close sequences
  function automatic logic [7:0] comment_byte();
    case ($urandom_range(0, 4))
      0: return CH_STAR;
      1: return CH_SLASH;
      2: return CH_SPACE;
      default: return rand_letter();
    endcase
  endfunction

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
  endtask

  // one piece of source text: mostly well formed, some noise
  task automatic add_snippet();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // keyword, sometimes spoiled by a trailing byte
      queue_text(kw_name($urandom_range(0, 7)));
      if ($urandom_range(0, 3) == 0) src_bytes.push_back(rand_alnum());
    end else if (pick < 35) begin
      // identifier, up to eight bytes so long words show up
      n = $urandom_range(1, 8);
      src_bytes.push_back(rand_letter());
      repeat (n - 1) src_bytes.push_back(rand_alnum());
    end else if (pick < 47) begin
      // number, sometimes with a letter in it
      n = $urandom_range(1, 6);
      repeat (n) src_bytes.push_back(rand_digit());
      if ($urandom_range(0, 3) == 0) src_bytes.push_back(rand_letter());
    end else if (pick < 72) begin
      queue_text(op_text($urandom_range(0, 18)));
    end else if (pick < 80) begin
      // comment closed normally, by a star run, or cut off by newline
      queue_text("/*");
      repeat ($urandom_range(0, 6)) src_bytes.push_back(comment_byte());
      case ($urandom_range(0, 3))
        0: queue_text("**/");
        1: src_bytes.push_back(CH_NL);
        default: queue_text("*/");
      endcase
    end else if (pick < 88) begin
      src_bytes.push_back(CH_NL);
    end else if (pick < 93) begin
      src_bytes.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
    end else begin
      src_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // tokens run together half the time
    if ($urandom_range(0, 1) == 0) src_bytes.push_back(CH_SPACE);
  endtask

  // directed rows: expected token typed in only where it is obvious
  typedef struct packed {
    logic [7:0] c;
    logic       typed;
    logic [4:0] kind;
    logic       err;
  } dir_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;
  localparam int   DIR_ROWS = 25;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{8'h00,     TYPED, TOK_ERR, 1'b1},  // lowest byte right after reset
    '{8'hff,     TYPED, TOK_ERR, 1'b1},  // highest byte, not ascii
    '{CH_NL,     TYPED, TOK_END, 1'b1},  // line verdict carries the flag
    '{8'h64,     PRED,  TOK_ID,  1'b0},  // d
    '{8'h6f,     PRED,  TOK_ID,  1'b0},  // o
    '{CH_LPAR,   PRED,  TOK_ID,  1'b0},  // keyword closed by a paren
    '{8'h39,     PRED,  TOK_ID,  1'b0},  // 9
    '{8'h78,     PRED,  TOK_ID,  1'b0},  // x, number turns identifier
    '{CH_BANG,   PRED,  TOK_ID,  1'b0},
    '{CH_EQ,     PRED,  TOK_ID,  1'b0},  // not equal
    '{CH_GT,     PRED,  TOK_ID,  1'b0},
    '{CH_LT,     PRED,  TOK_ID,  1'b0},  // greater, then less is pending
    '{CH_EQ,     PRED,  TOK_ID,  1'b0},  // less or equal
    '{CH_SLASH,  PRED,  TOK_ID,  1'b0},
    '{CH_STAR,   PRED,  TOK_ID,  1'b0},  // comment opens
    '{CH_STAR,   PRED,  TOK_ID,  1'b0},
    '{CH_STAR,   PRED,  TOK_ID,  1'b0},
    '{CH_SLASH,  PRED,  TOK_ID,  1'b0},  // star run then slash closes it
    '{8'h7c,     TYPED, TOK_ERR, 1'b1},  // bar alone is an error
    '{CH_TAB,    PRED,  TOK_ID,  1'b0},
    '{CH_EQ,     PRED,  TOK_ID,  1'b0},
    '{CH_NL,     PRED,  TOK_ID,  1'b0},  // assign flushed before end of line
    '{CH_SLASH,  PRED,  TOK_ID,  1'b0},
    '{CH_STAR,   PRED,  TOK_ID,  1'b0},
    '{CH_NL,     TYPED, TOK_END, 1'b0}   // newline abandons the comment
  };

  // ---------------------------------------------------------------- checking

  // token requests: check against the oldest owed token, then pick next stall
  always @(posedge clk) begin
    token_t exp_tok;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("token kind %0d with none expected", out_token_kind));
      end else begin
        exp_tok = tokens_due.pop_front();
        if (out_token_kind !== exp_tok.kind || out_error_seen !== exp_tok.err ||
            out_last_of_item !== exp_tok.last)
          report_mismatch($sformatf("token got kind %0d err %b last %b, want %0d %b %b",
                                    out_token_kind, out_error_seen, out_last_of_item,
                                    exp_tok.kind, exp_tok.err, exp_tok.last));
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------- run

  initial begin
    token_t t;
    int sent;
    int drain;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_table[i]) begin
      send_byte(dir_table[i].c);
      if (dir_table[i].typed) begin
        t.kind = dir_table[i].kind;
        t.err = dir_table[i].err;
        t.last = 1'b1;
        tokens_due.push_back(t);
      end else begin
        queue_predicted();
      end
    end

    // random text in four idling phases: none, sender, sink, both lightly
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      // hold off until every owed token has come out
      in_valid <= 1'b0;
      @(posedge clk);
      while (tokens_due.size() != 0) @(posedge clk);
      sent = 0;
      while (sent < 150) begin
        if (src_bytes.size() == 0) add_snippet();
        t = 0;
        send_byte(src_bytes[0]);
        sent++;
        void'(src_bytes.pop_front());
        queue_predicted();
      end
    end
    // leftover text and a closing newline flush any pending token
    while (src_bytes.size() != 0) begin
      send_byte(src_bytes.pop_front());
      queue_predicted();
    end
    send_byte(CH_NL);
    queue_predicted();
    in_valid <= 1'b0;

    // drain, then keep watching to catch stray tokens
    drain = 0;
    while (tokens_due.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (tokens_due.size() != 0)
      report_mismatch($sformatf("%0d tokens never came out", tokens_due.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
